// ----- design/vcbl_pkg.sv -----
// Shared widths, constants and sequencer types for the biquad lowpass block.
package vcbl_pkg;

    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DVD_W       = 64;
    localparam int DSR_W       = 32;
    localparam int FRAC_W      = 30;
    localparam int COEF_SHIFT  = 28;
    localparam int VAL_W       = 35;
    localparam int ACC_W       = 40;
    localparam int SAMPLE_W    = 16;
    localparam int CUTOFF_W    = 15;
    localparam int QF_W        = 8;
    localparam int STATE_Y_W   = 32;
    localparam int OUT_W       = 24;

    localparam int DEFAULT_SAMPLE_RATE_HZ = 44100;
    localparam logic [QF_W-1:0] DEFAULT_QUALITY = 8'd50;

    localparam logic [MUL_W-1:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [MUL_W-1:0] QF_ONE      = 32'h4000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // One entry per operation on the shared multiplier or divider.
    typedef enum logic [4:0] {
        STEP_TURN,
        STEP_X,
        STEP_X2,
        STEP_SD72,
        STEP_SD42,
        STEP_SM42,
        STEP_SD20,
        STEP_SM20,
        STEP_SD6,
        STEP_SM6,
        STEP_SMX,
        STEP_CD90,
        STEP_CD56,
        STEP_CM56,
        STEP_CD30,
        STEP_CM30,
        STEP_CD12,
        STEP_CM12,
        STEP_CD2,
        STEP_CM2,
        STEP_ALPHA,
        STEP_CB0,
        STEP_CB1,
        STEP_CA1,
        STEP_CA2,
        STEP_F0,
        STEP_F1,
        STEP_F2,
        STEP_F3,
        STEP_F4
    } step_t;

endpackage

// ----- design/vcbl_serial_mul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module vcbl_serial_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vcbl_pkg::MUL_W-1:0]  a,
    input  logic [vcbl_pkg::MUL_W-1:0]  b,
    output logic                        done,
    output logic [vcbl_pkg::PROD_W-1:0] product
);
    import vcbl_pkg::*;

    localparam int CNT_W = $clog2(MUL_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MUL_W-1:0]    a_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [MUL_W:0]      sum;

    // add multiplicand to the upper half when the low bit is set, then shift right
    assign sum = {1'b0, prod_reg[PROD_W-1:MUL_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{MUL_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[MUL_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ----- design/vcbl_serial_div.sv -----
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
module vcbl_serial_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [vcbl_pkg::DVD_W-1:0] dividend,
    input  logic [vcbl_pkg::DSR_W-1:0] divisor,
    output logic                       done,
    output logic [vcbl_pkg::DVD_W-1:0] quotient
);
    import vcbl_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DSR_W-1:0]   dsr_reg;
    logic [DSR_W-1:0]   rem_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVD_W-1:0]   quo_reg;
    logic [DSR_W:0]     shifted;
    logic [DSR_W+1:0]   diff;
    logic               fits;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits    = !diff[DSR_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/variable_cutoff_biquad_lowpass.sv -----
// Top level: variable-cutoff cookbook lowpass biquad with serial coefficient math.
//
// Each input transaction carries a sample (Q1.15) and a cutoff in hertz. The block
// derives the phase step cutoff/SAMPLE_RATE_HZ, evaluates sin and cos by Taylor
// series, forms alpha = sin/(2Q) and the lowpass coefficients normalized by a0, and
// runs one biquad step; the result is Q8.16, saturated to 24 bits, while the stored
// output history keeps 32 bits. All arithmetic runs on one bit-serial 32x32
// multiplier and one bit-serial 64/32 restoring divider, driven by a step
// sequencer: 15 divisions and 15 multiplications, each issued in ST_ISSUE
// and captured in ST_WAIT. A new transaction is taken only when the sequencer
// is idle; a finished result sits in the output register and the next
// transaction may be computed while it waits. Q is written through the cfg
// channel (always ready, write only while idle); Q of zero acts as one.
module variable_cutoff_biquad_lowpass #(
    parameter int SAMPLE_RATE_HZ = vcbl_pkg::DEFAULT_SAMPLE_RATE_HZ
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic [vcbl_pkg::CUTOFF_W-1:0]         cutoff_hz,
    input  logic signed [vcbl_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [vcbl_pkg::OUT_W-1:0]     filtered_sample,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vcbl_pkg::QF_W-1:0]             quality_factor
);
    import vcbl_pkg::*;

    localparam logic signed [VAL_W-1:0] ONE_S   = 35'sd1073741824;
    localparam logic signed [ACC_W-1:0] Y_MAX   = 40'sd2147483647;
    localparam logic signed [ACC_W-1:0] Y_MIN   = -40'sd2147483648;
    localparam logic signed [STATE_Y_W-1:0] O_MAX = 32'sd8388607;
    localparam logic signed [STATE_Y_W-1:0] O_MIN = -32'sd8388608;

    function automatic logic [MUL_W-1:0] one_minus(input logic [MUL_W-1:0] v);
        one_minus = (v > QF_ONE) ? '0 : QF_ONE - v;
    endfunction

    function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] v);
        mag = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    endfunction

    // sequencer
    state_t state_reg, state_next;
    step_t  step_reg;

    // configuration and filter history
    logic [QF_W-1:0]               qf_reg;
    logic signed [SAMPLE_W-1:0]    x1_reg, x2h_reg;
    logic signed [STATE_Y_W-1:0]   y1_reg, y2_reg;

    // per-transaction working registers
    logic [CUTOFF_W-1:0]           cutoff_reg;
    logic signed [SAMPLE_W-1:0]    x0_reg;
    logic [MUL_W-1:0]              turn_reg, x_reg, x2_reg, t_reg, d_reg;
    logic signed [VAL_W-1:0]       s_reg, c_reg, alpha_reg;
    logic [MUL_W-1:0]              cb0_mag_reg, cb1_mag_reg, ca1_mag_reg, ca2_mag_reg;
    logic                          cb0_neg_reg, cb1_neg_reg, ca1_neg_reg, ca2_neg_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    // output register
    logic                          result_valid_reg;
    logic signed [OUT_W-1:0]       filtered_reg;

    // unit interface
    logic                          op_div;
    logic [DVD_W-1:0]              div_dvd;
    logic [DSR_W-1:0]              div_dsr;
    logic [MUL_W-1:0]              mul_a, mul_b;
    logic                          term_neg;
    logic                          mul_start, div_start, mul_done, div_done;
    logic [PROD_W-1:0]             mul_p;
    logic [DVD_W-1:0]              div_q;
    logic                          unit_done;
    logic                          accept, finish_fire;

    // derived values
    logic [MUL_W-1:0]              mul_hi;
    logic [MUL_W-1:0]              c_raw;
    logic [QF_W:0]                 qf_twice;
    logic signed [VAL_W-1:0]       a0;
    logic signed [VAL_W-1:0]       num_b;
    logic [VAL_W-1:0]              num_b_mag;
    logic signed [VAL_W-1:0]       num_a1;
    logic signed [VAL_W-1:0]       num_a2;
    logic signed [VAL_W-1:0]       x0_v, x1_v, x2_v, y1_v, y2_v;
    logic signed [VAL_W-1:0]       alpha_q;
    logic signed [ACC_W-1:0]       term_v;
    logic signed [ACC_W-1:0]       y_sat;
    logic signed [STATE_Y_W-1:0]   y32;
    logic signed [STATE_Y_W-1:0]   y_out;

    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;
    assign unit_done    = op_div ? div_done : mul_done;
    assign mul_hi       = mul_p[FRAC_W+MUL_W-1:FRAC_W];
    assign c_raw        = one_minus(mul_hi);
    assign qf_twice     = (qf_reg == '0) ? 9'd2 : {qf_reg, 1'b0};
    assign a0           = ONE_S + alpha_reg;
    assign num_b        = ONE_S - c_reg;
    assign num_b_mag    = mag(num_b);
    assign num_a1       = c_reg <<< 1;
    assign num_a2       = ONE_S - alpha_reg;
    assign x0_v         = $signed({{(VAL_W-SAMPLE_W-1){x0_reg[SAMPLE_W-1]}}, x0_reg, 1'b0});
    assign x1_v         = $signed({{(VAL_W-SAMPLE_W-1){x1_reg[SAMPLE_W-1]}}, x1_reg, 1'b0});
    assign x2_v         = $signed({{(VAL_W-SAMPLE_W-1){x2h_reg[SAMPLE_W-1]}}, x2h_reg, 1'b0});
    assign y1_v         = $signed({{(VAL_W-STATE_Y_W){y1_reg[STATE_Y_W-1]}}, y1_reg});
    assign y2_v         = $signed({{(VAL_W-STATE_Y_W){y2_reg[STATE_Y_W-1]}}, y2_reg});
    assign alpha_q      = $signed({1'b0, div_q[VAL_W-2:0]});
    assign term_v       = $signed({{(ACC_W-(PROD_W-COEF_SHIFT)){1'b0}},
                                   mul_p[PROD_W-1:COEF_SHIFT]});

    // saturate to the 32-bit history range, then to the 24-bit output range
    assign y_sat = (acc_reg > Y_MAX) ? Y_MAX : ((acc_reg < Y_MIN) ? Y_MIN : acc_reg);
    assign y32   = y_sat[STATE_Y_W-1:0];
    assign y_out = (y32 > O_MAX) ? O_MAX : ((y32 < O_MIN) ? O_MIN : y32);

    // operand decode for the current step
    always_comb
    begin
        op_div   = 1'b0;
        div_dvd  = '0;
        div_dsr  = '0;
        mul_a    = '0;
        mul_b    = '0;
        term_neg = 1'b0;
        unique case (step_reg) inside
            STEP_TURN:
            begin
                op_div  = 1'b1;
                div_dvd = {{(DVD_W-CUTOFF_W-MUL_W){1'b0}}, cutoff_reg, {MUL_W{1'b0}}};
                div_dsr = DSR_W'(SAMPLE_RATE_HZ);
            end
            STEP_X:
            begin
                mul_a = {2'b00, turn_reg[FRAC_W-1:0]};
                mul_b = HALF_PI_Q30;
            end
            STEP_X2:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            STEP_SD72, STEP_SD42, STEP_SD20, STEP_SD6,
            STEP_CD90, STEP_CD56, STEP_CD30, STEP_CD12, STEP_CD2:
            begin
                op_div  = 1'b1;
                div_dvd = {{(DVD_W-MUL_W){1'b0}}, x2_reg};
                case (step_reg)
                    STEP_SD72: div_dsr = 32'd72;
                    STEP_SD42: div_dsr = 32'd42;
                    STEP_SD20: div_dsr = 32'd20;
                    STEP_SD6:  div_dsr = 32'd6;
                    STEP_CD90: div_dsr = 32'd90;
                    STEP_CD56: div_dsr = 32'd56;
                    STEP_CD30: div_dsr = 32'd30;
                    STEP_CD12: div_dsr = 32'd12;
                    default:   div_dsr = 32'd2;
                endcase
            end
            STEP_SM42, STEP_SM20, STEP_SM6, STEP_CM56, STEP_CM30, STEP_CM12, STEP_CM2:
            begin
                mul_a = d_reg;
                mul_b = t_reg;
            end
            STEP_SMX:
            begin
                mul_a = x_reg;
                mul_b = t_reg;
            end
            STEP_ALPHA:
            begin
                op_div  = 1'b1;
                div_dvd = {{(DVD_W-VAL_W){1'b0}}, mag(s_reg)};
                div_dsr = {{(DSR_W-QF_W-1){1'b0}}, qf_twice};
            end
            STEP_CB0:
            begin
                op_div  = 1'b1;
                div_dvd = {2'b00, num_b_mag[VAL_W-1:1], {COEF_SHIFT{1'b0}}};
                div_dsr = DSR_W'(a0);
            end
            STEP_CB1:
            begin
                op_div  = 1'b1;
                div_dvd = {1'b0, num_b_mag, {COEF_SHIFT{1'b0}}};
                div_dsr = DSR_W'(a0);
            end
            STEP_CA1:
            begin
                op_div  = 1'b1;
                div_dvd = {1'b0, mag(num_a1), {COEF_SHIFT{1'b0}}};
                div_dsr = DSR_W'(a0);
            end
            STEP_CA2:
            begin
                op_div  = 1'b1;
                div_dvd = {1'b0, mag(num_a2), {COEF_SHIFT{1'b0}}};
                div_dsr = DSR_W'(a0);
            end
            STEP_F0:
            begin
                mul_a    = cb0_mag_reg;
                mul_b    = MUL_W'(mag(x0_v));
                term_neg = cb0_neg_reg ^ x0_v[VAL_W-1];
            end
            STEP_F1:
            begin
                mul_a    = cb1_mag_reg;
                mul_b    = MUL_W'(mag(x1_v));
                term_neg = cb1_neg_reg ^ x1_v[VAL_W-1];
            end
            STEP_F2:
            begin
                mul_a    = cb0_mag_reg;
                mul_b    = MUL_W'(mag(x2_v));
                term_neg = cb0_neg_reg ^ x2_v[VAL_W-1];
            end
            STEP_F3:
            begin
                mul_a    = ca1_mag_reg;
                mul_b    = MUL_W'(mag(y1_v));
                term_neg = !(ca1_neg_reg ^ y1_v[VAL_W-1]);
            end
            STEP_F4:
            begin
                mul_a    = ca2_mag_reg;
                mul_b    = MUL_W'(mag(y2_v));
                term_neg = !(ca2_neg_reg ^ y2_v[VAL_W-1]);
            end
            default:
            begin
                op_div = 1'b0;
            end
        endcase
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and control outputs
    always_comb
    begin
        state_next   = state_reg;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        finish_fire  = 1'b0;
        sample_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                mul_start  = !op_div;
                div_start  = op_div;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = (step_reg == STEP_F4) ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    finish_fire = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state: step counter, config, history, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_TURN;
            qf_reg           <= DEFAULT_QUALITY;
            x1_reg           <= '0;
            x2h_reg          <= '0;
            y1_reg           <= '0;
            y2_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                qf_reg <= quality_factor;
            end
            if (accept)
            begin
                step_reg <= STEP_TURN;
            end
            else if (state_reg == ST_WAIT && unit_done && step_reg != STEP_F4)
            begin
                step_reg <= step_t'(5'(step_reg) + 5'd1);
            end
            if (finish_fire)
            begin
                x2h_reg          <= x1_reg;
                x1_reg           <= x0_reg;
                y2_reg           <= y1_reg;
                y1_reg           <= y32;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath captures
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cutoff_reg <= cutoff_hz;
            x0_reg     <= sample_in;
            acc_reg    <= '0;
        end
        if (finish_fire)
        begin
            filtered_reg <= y_out[OUT_W-1:0];
        end
        if (state_reg == ST_WAIT && unit_done)
        begin
            case (step_reg) inside
                STEP_TURN:  turn_reg <= div_q[MUL_W-1:0];
                STEP_X:     x_reg    <= mul_hi;
                STEP_X2:    x2_reg   <= mul_hi;
                STEP_SD72, STEP_CD90:
                begin
                    t_reg <= one_minus(div_q[MUL_W-1:0]);
                end
                STEP_SD42, STEP_SD20, STEP_SD6, STEP_CD56, STEP_CD30, STEP_CD12, STEP_CD2:
                begin
                    d_reg <= div_q[MUL_W-1:0];
                end
                STEP_SM42, STEP_SM20, STEP_SM6, STEP_CM56, STEP_CM30, STEP_CM12:
                begin
                    t_reg <= one_minus(mul_hi);
                end
                STEP_SMX:   s_reg <= $signed({{(VAL_W-MUL_W){1'b0}}, mul_hi});
                STEP_CM2:
                begin
                    // fold the first-quadrant pair back to the full turn
                    unique case (turn_reg[MUL_W-1:MUL_W-2])
                        2'd0:
                        begin
                            c_reg <= $signed({{(VAL_W-MUL_W){1'b0}}, c_raw});
                        end
                        2'd1:
                        begin
                            s_reg <= $signed({{(VAL_W-MUL_W){1'b0}}, c_raw});
                            c_reg <= -s_reg;
                        end
                        2'd2:
                        begin
                            s_reg <= -s_reg;
                            c_reg <= -$signed({{(VAL_W-MUL_W){1'b0}}, c_raw});
                        end
                        default:
                        begin
                            s_reg <= -$signed({{(VAL_W-MUL_W){1'b0}}, c_raw});
                            c_reg <= s_reg;
                        end
                    endcase
                end
                STEP_ALPHA: alpha_reg <= s_reg[VAL_W-1] ? -alpha_q : alpha_q;
                STEP_CB0:
                begin
                    cb0_mag_reg <= div_q[MUL_W-1:0];
                    cb0_neg_reg <= num_b[VAL_W-1];
                end
                STEP_CB1:
                begin
                    cb1_mag_reg <= div_q[MUL_W-1:0];
                    cb1_neg_reg <= num_b[VAL_W-1];
                end
                STEP_CA1:
                begin
                    ca1_mag_reg <= div_q[MUL_W-1:0];
                    ca1_neg_reg <= !c_reg[VAL_W-1];
                end
                STEP_CA2:
                begin
                    ca2_mag_reg <= div_q[MUL_W-1:0];
                    ca2_neg_reg <= num_a2[VAL_W-1];
                end
                STEP_F0, STEP_F1, STEP_F2, STEP_F3, STEP_F4:
                begin
                    acc_reg <= term_neg ? acc_reg - term_v : acc_reg + term_v;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    vcbl_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    vcbl_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign result_valid    = result_valid_reg;
    assign filtered_sample = filtered_reg;

endmodule
